>>> hdl/ttip_pkg.sv
// Shared types, constants and helper functions of the text to integer parser.
`timescale 1ns / 1ps
`default_nettype none

package ttip_pkg;

	// Saturation point of the character counter and the widths that follow from it.
	localparam int MAX_OFFSET = 255;
	localparam int POS_W      = $clog2(MAX_OFFSET + 1);
	localparam int OFF_W      = 8;
	localparam int VALUE_W    = 64;
	localparam int RADIX_W    = 6;
	localparam int CHAR_W     = 8;
	localparam int DIGIT_W    = 5;

	// Configuration register indexes.
	localparam logic REG_NUMBER_BASE = 1'b0;
	localparam logic REG_SIGNED_MODE = 1'b1;

	// Radix values picked by prefix detection.
	localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;
	localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;

	// Characters with a special role.
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;

	// Marker returned by hex_value for a character that is no hex digit.
	localparam logic [DIGIT_W-1:0] DIGIT_NONE = 5'd16;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SIGN,
		PH_PREFIX,
		PH_ZERO,
		PH_X,
		PH_DIGITS
	} phase_t;

	typedef struct packed {
		phase_t               phase;
		logic [VALUE_W-1:0]   acc;
		logic [RADIX_W-1:0]   radix;
		logic                 neg;
		logic [POS_W-1:0]     pos;
	} parse_state_t;

	typedef struct packed {
		logic [RADIX_W-1:0] number_base;
		logic               signed_mode;
	} parse_cfg_t;

	// Value of a hex digit in either case, DIGIT_NONE for anything else.
	function automatic logic [DIGIT_W-1:0] hex_value(input logic [CHAR_W-1:0] c);
		logic [DIGIT_W-1:0] d;
		d = DIGIT_NONE;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = DIGIT_W'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d = DIGIT_W'(c - 8'h61 + 8'd10);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d = DIGIT_W'(c - 8'h41 + 8'd10);
		end
		return d;
	endfunction

	// Character counter step that holds at the saturation point.
	function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] p);
		logic [POS_W-1:0] r;
		r = (p == POS_W'(MAX_OFFSET)) ? p : p + POS_W'(1);
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hdl/ttip_step.sv
// Next-state and result logic of the parser for one character.
`timescale 1ns / 1ps
`default_nettype none

module ttip_step (
	input  wire ttip_pkg::parse_state_t          cur,
	input  wire ttip_pkg::parse_cfg_t            cfg,
	input  wire logic [ttip_pkg::CHAR_W-1:0]     char_code,
	input  wire logic                            start,
	output ttip_pkg::parse_state_t               nxt,
	output logic                                 emit,
	output logic [ttip_pkg::VALUE_W-1:0]         value,
	output logic [ttip_pkg::OFF_W-1:0]           offset
);
	import ttip_pkg::*;

	logic [DIGIT_W-1:0] digit;
	logic               do_take;

	assign digit = hex_value(char_code);

	// Walk the phases for this character; a start flag restarts the string first.
	always_comb begin
		nxt     = cur;
		emit    = 1'b0;
		do_take = 1'b0;
		if (start) begin
			nxt.phase = PH_SIGN;
			nxt.acc   = '0;
			nxt.radix = '0;
			nxt.neg   = 1'b0;
			nxt.pos   = '0;
		end
		unique case (nxt.phase)
			PH_SIGN, PH_PREFIX: begin
				if (nxt.phase == PH_SIGN && cfg.signed_mode && char_code == CHAR_MINUS) begin
					nxt.neg   = 1'b1;
					nxt.pos   = sat_inc(nxt.pos);
					nxt.phase = PH_PREFIX;
				end else if (cfg.number_base == '0 && char_code == CHAR_ZERO) begin
					nxt.radix = RADIX_OCT;
					nxt.pos   = sat_inc(nxt.pos);
					nxt.phase = PH_ZERO;
				end else begin
					nxt.radix = (cfg.number_base == '0) ? RADIX_DEC : cfg.number_base;
					do_take   = 1'b1;
				end
			end
			PH_ZERO: begin
				if (char_code == CHAR_X) begin
					nxt.phase = PH_X;
				end else begin
					do_take = 1'b1;
				end
			end
			PH_X: begin
				if (digit != DIGIT_NONE) begin
					// The 'x' is counted only once a hex digit confirms the prefix.
					nxt.radix = RADIX_HEX;
					nxt.pos   = sat_inc(nxt.pos);
					do_take   = 1'b1;
				end else begin
					emit = 1'b1;
				end
			end
			PH_DIGITS: begin
				do_take = 1'b1;
			end
			default: begin
			end
		endcase

		// Accumulate a hex digit that fits the radix, otherwise the number ends here.
		if (do_take) begin
			if (digit != DIGIT_NONE && {1'b0, digit} < nxt.radix) begin
				nxt.acc   = VALUE_W'(nxt.acc * {{(VALUE_W-RADIX_W){1'b0}}, nxt.radix})
				            + {{(VALUE_W-DIGIT_W){1'b0}}, digit};
				nxt.pos   = sat_inc(nxt.pos);
				nxt.phase = PH_DIGITS;
			end else begin
				emit = 1'b1;
			end
		end
		if (emit) begin
			nxt.phase = PH_IDLE;
		end
	end

	// Result fields, negated when a minus was taken and the offset clipped to a byte.
	always_comb begin
		value = nxt.neg ? (VALUE_W'(0) - nxt.acc) : nxt.acc;
		if (32'(nxt.pos) > 32'd255) begin
			offset = '1;
		end else begin
			offset = OFF_W'(nxt.pos);
		end
	end

endmodule

`default_nettype wire

>>> hdl/text_to_integer_parser.sv
// Top level of the streaming text to 64-bit integer parser.
// The slave stream carries one character per beat in s_tdata, with s_tuser
// high on the first character of a new string. When a character ends the
// number, one beat leaves on the master stream: the value in the low 64 bits
// of m_tdata and the count of characters consumed before the stopping one in
// the top byte. Characters between the end of a number and the next start
// produce nothing, and a new start abandons an unfinished number silently.
// Each character is decoded and accumulated by one 64 by 6 multiply-add in
// combinational logic, so the block takes one beat per clock while the slave
// side is not stalled; a result appears on the master side in the cycle after
// the character that ends the number. The output register doubles as the
// buffer between the two sides: a new character is taken while the result is
// being drained, and the slave side stalls only when a result waits and m_tready is low.
// Reset clears the parse state, the output valid and both configuration
// registers (auto-detected base, unsigned mode). The configuration port
// writes number_base at index 0 and signed_mode at index 1; write it only
// while no string is in progress.
`timescale 1ns / 1ps
`default_nettype none

module text_to_integer_parser (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	// Configuration writes.
	input  wire  logic        cfg_we,
	input  wire  logic        cfg_index,
	input  wire  logic [5:0]  cfg_wdata,
	// Character stream.
	input  wire  logic        s_tvalid,
	output logic              s_tready,
	input  wire  logic [7:0]  s_tdata,   // [7:0] character_code
	input  wire  logic        s_tuser,   // [0] string_start
	// Result stream.
	output logic              m_tvalid,
	input  wire  logic        m_tready,
	output logic [71:0]       m_tdata    // [63:0] parsed_value, [71:64] end_offset
);
	import ttip_pkg::*;

	parse_state_t         state_q;
	parse_state_t         state_nxt;
	parse_cfg_t           cfg_q;
	logic                 emit;
	logic [VALUE_W-1:0]   value;
	logic [OFF_W-1:0]     offset;
	logic                 in_beat;
	logic                 out_valid_q;
	logic [VALUE_W-1:0]   value_q;
	logic [OFF_W-1:0]     offset_q;

	assign s_tready = !out_valid_q || m_tready;
	assign in_beat  = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {offset_q, value_q};

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.number_base <= '0;
			cfg_q.signed_mode <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUMBER_BASE: cfg_q.number_base <= cfg_wdata;
				REG_SIGNED_MODE: cfg_q.signed_mode <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	ttip_step u_step (
		.cur       (state_q),
		.cfg       (cfg_q),
		.char_code (s_tdata),
		.start     (s_tuser),
		.nxt       (state_nxt),
		.emit      (emit),
		.value     (value),
		.offset    (offset)
	);

	// Parse state advances on every accepted character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= PH_IDLE;
			state_q.acc   <= '0;
			state_q.radix <= '0;
			state_q.neg   <= 1'b0;
			state_q.pos   <= '0;
		end else if (in_beat) begin
			state_q <= state_nxt;
		end
	end

	// Output valid: set by a finished number, cleared when the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_beat && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (in_beat && emit) begin
			value_q  <= value;
			offset_q <= offset;
		end
	end

endmodule

`default_nettype wire

>>> tb/sv/text_to_integer_parser_tb.sv
// Self-checking stream testbench for text_to_integer_parser with a built-in parse predictor.
`timescale 1ns / 1ps

module text_to_integer_parser_tb;
	import ttip_pkg::*;

	localparam int CYCLE_LIMIT     = 600000;
	localparam int PHASE_COUNT     = 12;
	localparam int ITEMS_PER_PHASE = 85;
	localparam int DIGIT_INVALID   = 99;
	localparam int LONG_HOLD       = 300;

	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_X = 8'h58;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_SEMI    = 8'h3B;

	// One character beat and one parse result.
	typedef struct packed {
		logic [7:0] code;
		logic       first;
	} char_beat_t;

	typedef struct packed {
		logic [63:0] value;
		logic [7:0]  offset;
	} parse_result_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = REG_NUMBER_BASE;
	logic [5:0]  cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [71:0] m_tdata;

	char_beat_t    pending_chars[$];
	parse_result_t expected_results[$];
	char_beat_t    next_beat;
	parse_result_t oldest_result;

	// Predictor copy of the configuration and the parse state.
	int     cfg_base_copy;
	bit     cfg_signed_copy;
	phase_t pred_phase;
	logic [63:0] pred_acc;
	int     pred_radix;
	bit     pred_neg;
	int     pred_pos;

	int cycle_count      = 0;
	int mismatch_count   = 0;
	int chars_accepted   = 0;
	int results_checked  = 0;
	int stimulus_count   = 0;
	int burst_left       = 0;
	int gap_left         = 0;
	int ready_mode       = 0;
	int mode_left        = 0;
	int hold_left        = 0;
	bit held_once        = 0;

	int phase_bases[PHASE_COUNT]   = '{0, 10, 16, 8, 1, 2, 36, 17, 63, 0, 10, 0};
	bit phase_signed[PHASE_COUNT]  = '{1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 1};

	text_to_integer_parser u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Free-running clock, 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Digit value of a hex character in either case, DIGIT_INVALID otherwise.
	function automatic int digit_of(input logic [7:0] code);
		int d;
		d = DIGIT_INVALID;
		if (code >= CHAR_ZERO && code < CHAR_ZERO + 8'd10) d = int'(code - CHAR_ZERO);
		if (code >= CH_LOWER_A && code < CH_LOWER_A + 8'd6) d = int'(code - CH_LOWER_A) + 10;
		if (code >= CH_UPPER_A && code < CH_UPPER_A + 8'd6) d = int'(code - CH_UPPER_A) + 10;
		return d;
	endfunction

	// The character counter saturates at the top of its range.
	function automatic void advance_pos();
		pred_pos = (pred_pos + 1 > MAX_OFFSET) ? MAX_OFFSET : pred_pos + 1;
	endfunction

	// Accumulates a digit below the active radix; returns 0 when the character ends the number.
	function automatic bit absorb_digit(input logic [7:0] code);
		int d;
		d = digit_of(code);
		if (d >= pred_radix) return 1'b0;
		pred_acc   = pred_acc * 64'(pred_radix) + 64'(d);
		pred_phase = PH_DIGITS;
		advance_pos();
		return 1'b1;
	endfunction

	// Advances the predicted parse by one accepted character and queues any result.
	task automatic parse_char(input logic [7:0] code, input logic first);
		bit finished;
		finished = 1'b0;
		if (first) begin
			pred_acc   = '0;
			pred_radix = 0;
			pred_neg   = 1'b0;
			pred_pos   = 0;
			pred_phase = PH_SIGN;
		end
		case (pred_phase)
			PH_SIGN, PH_PREFIX: begin
				if (pred_phase == PH_SIGN && cfg_signed_copy && code == CHAR_MINUS) begin
					pred_neg   = 1'b1;
					pred_phase = PH_PREFIX;
					advance_pos();
				end else if (cfg_base_copy == 0 && code == CHAR_ZERO) begin
					pred_radix = int'(RADIX_OCT);
					pred_phase = PH_ZERO;
					advance_pos();
				end else begin
					pred_radix = (cfg_base_copy == 0) ? int'(RADIX_DEC) : cfg_base_copy;
					finished   = !absorb_digit(code);
				end
			end
			PH_ZERO: begin
				if (code == CHAR_X) pred_phase = PH_X;
				else finished = !absorb_digit(code);
			end
			PH_X: begin
				// The x only counts once a hex digit follows it.
				if (digit_of(code) < 16) begin
					pred_radix = int'(RADIX_HEX);
					advance_pos();
					finished = !absorb_digit(code);
				end else begin
					finished = 1'b1;
				end
			end
			PH_DIGITS: finished = !absorb_digit(code);
			default: ;
		endcase
		if (finished) begin
			expected_results.push_back('{value: pred_neg ? 64'd0 - pred_acc : pred_acc,
				offset: (pred_pos > 255) ? 8'd255 : 8'(pred_pos)});
			pred_phase = PH_IDLE;
		end
	endtask

	// Sender: bursts of beats with random gaps, fed from pending_chars.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			s_tuser    <= 1'b0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				parse_char(s_tdata, s_tuser);
				chars_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (pending_chars.size() > 0) begin
					next_beat = pending_chars.pop_front();
					s_tvalid  <= 1'b1;
					s_tdata   <= next_beat.code;
					s_tuser   <= next_beat.first;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall pattern changes now and then, with one long hold-off and rare short ones.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			ready_mode <= 0;
			mode_left  <= 0;
			hold_left  <= 0;
			held_once  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (!held_once && results_checked >= 25) begin
			held_once <= 1'b1;
			hold_left <= LONG_HOLD;
			m_tready  <= 1'b0;
		end else if ($urandom_range(0, 2999) == 0) begin
			hold_left <= $urandom_range(30, 120);
			m_tready  <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode <= $urandom_range(0, 3);
				mode_left  <= $urandom_range(16, 96);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (ready_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= cycle_count[2];
			endcase
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		mismatch_count++;
		$display("mismatch in %s at cycle %0d: got %h, expected %h", what, cycle_count, got, want);
	endtask

	// Monitor: each result beat is checked against the oldest expected result.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result beat", m_tdata[63:0], '0);
			end else begin
				oldest_result = expected_results.pop_front();
				if (m_tdata[63:0] !== oldest_result.value)
					report_mismatch("parsed_value", m_tdata[63:0], oldest_result.value);
				if (m_tdata[71:64] !== oldest_result.offset)
					report_mismatch("end_offset", 64'(m_tdata[71:64]), 64'(oldest_result.offset));
			end
			results_checked++;
		end
	end

	// Cycle counter with a run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic index, input logic [5:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == REG_NUMBER_BASE) cfg_base_copy = int'(value);
		else cfg_signed_copy = value[0];
	endtask

	// Waits until every queued beat went in and every expected result came out.
	// The condition is sampled on the falling edge, once the sender has settled.
	task automatic wait_drained();
		@(negedge clk);
		while (pending_chars.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(negedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic push_char(input logic [7:0] code, inout bit first);
		pending_chars.push_back('{code: code, first: first});
		first = 1'b0;
		stimulus_count++;
	endtask

	function automatic logic [7:0] digit_char(input int v);
		if (v < 10) return 8'(CHAR_ZERO + v);
		return 8'(($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + v - 10);
	endfunction

	// Queues one number string: optional minus, optional prefix, digits, usually a stopping character.
	task automatic queue_number(input bit force_long);
		bit first;
		int eff;
		int n;
		int shape;
		first = 1'b1;
		eff   = (cfg_base_copy == 0) ? 10 : cfg_base_copy;
		if ($urandom_range(0, 2) == 0) push_char(CHAR_MINUS, first);
		if (cfg_base_copy == 0) begin
			shape = $urandom_range(0, 3);
			if (shape >= 1) begin
				push_char(CHAR_ZERO, first);
				eff = 8;
			end
			if (shape >= 2) begin
				push_char(CHAR_X, first);
				eff = 16;
			end
			// A bare prefix with nothing behind it.
			if (shape == 3) eff = 0;
		end
		n = $urandom_range(0, 14);
		if ($urandom_range(0, 5) == 0) n = $urandom_range(15, 26);
		if (force_long || $urandom_range(0, 79) == 0) n = $urandom_range(250, 290);
		if (eff == 0) n = 0;
		for (int k = 0; k < n; k++)
			push_char(digit_char($urandom_range(0, ((eff > 16) ? 16 : eff) - 1)), first);
		// Now and then the stop is left out, so the next start abandons the number.
		if ($urandom_range(0, 9) != 0) push_char(8'($urandom_range(0, 255)), first);
		for (int k = $urandom_range(0, 2); k > 0; k--)
			pending_chars.push_back('{code: 8'($urandom_range(0, 255)), first: 1'b0});
	endtask

	// Directed strings: prefixes, signs, idle characters, restarts and byte extremes.
	task automatic queue_directed();
		bit first;
		first = 1'b1;
		push_char(CHAR_MINUS, first);
		push_char(CHAR_ZERO, first);
		push_char(CHAR_X, first);
		push_char(8'h67, first);
		first = 1'b1;
		push_char(CHAR_MINUS, first);
		push_char(8'h7A, first);
		first = 1'b1;
		push_char(CHAR_ZERO, first);
		push_char(CHAR_X, first);
		push_char(8'h66, first);
		push_char(8'h46, first);
		push_char(CH_SEMI, first);
		first = 1'b1;
		push_char(CHAR_ZERO, first);
		push_char(8'h37, first);
		push_char(8'h37, first);
		push_char(8'h39, first);
		// Idle character, then a number cut short by a new start.
		pending_chars.push_back('{code: 8'h35, first: 1'b0});
		first = 1'b1;
		push_char(8'h31, first);
		push_char(8'h32, first);
		first = 1'b1;
		push_char(CHAR_MINUS, first);
		push_char(8'h33, first);
		push_char(CH_BANG, first);
		first = 1'b1;
		push_char(CHAR_ZERO, first);
		push_char(CH_UPPER_X, first);
		push_char(8'h31, first);
		first = 1'b1;
		push_char(8'hFF, first);
		first = 1'b1;
		push_char(8'h00, first);
	endtask

	// Main sequence: reset, then one configuration setting per phase.
	initial begin
		bit first;
		int phase_start;
		cfg_base_copy   = 0;
		cfg_signed_copy = 1'b0;
		pred_phase      = PH_IDLE;
		pred_acc        = '0;
		pred_radix      = 0;
		pred_neg        = 1'b0;
		pred_pos        = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			wait_drained();
			write_reg(REG_NUMBER_BASE, 6'(phase_bases[ph]));
			write_reg(REG_SIGNED_MODE, 6'(phase_signed[ph]));
			if (ph == 0) queue_directed();
			if (ph == 2) queue_number(1'b1);
			phase_start = stimulus_count;
			while (stimulus_count - phase_start < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 9) < 8) begin
					queue_number(1'b0);
				end else begin
					// Noise: random bytes with an occasional start.
					for (int k = $urandom_range(1, 6); k > 0; k--) begin
						first = ($urandom_range(0, 2) == 0);
						push_char(8'($urandom_range(0, 255)), first);
					end
				end
			end
			// A lone start on a non-digit closes any open string before the next setting.
			first = 1'b1;
			push_char(CH_BANG, first);
		end
		wait_drained();
		$display("%0d characters in %0d configuration settings, %0d numbers checked",
			chars_accepted, PHASE_COUNT, results_checked);
		$display("bases from auto-detect to 63, both sign modes, one long receiver hold-off");
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatch_count,
				expected_results.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> filelist.f
hdl/ttip_pkg.sv
hdl/ttip_step.sv
hdl/text_to_integer_parser.sv
tb/sv/text_to_integer_parser_tb.sv
